@@ design/sdx_pkg.sv @@
// Package for the Soundex encoder: word types, the letter group table and
// shared constants. Depends on nothing; every module of the block imports it.
package sdx_pkg;

   localparam int CODE_LENGTH_DEFAULT = 4;
   localparam int DIGIT_SLOTS         = 3;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [6:0] LEAD_BASE    = 7'h41;
   localparam logic [2:0] CODE_NONE    = 3'd0;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [6:0] lead_letter;
      logic [2:0] code_one;
      logic [2:0] code_two;
      logic [2:0] code_three;
      logic       no_letters;
   } rsp_type;

   // A byte after classification, as it waits in the queue.
   typedef struct packed {
      logic       letter;
      logic [4:0] idx;
      logic [2:0] code;
      logic       last;
   } class_type;

   // Handshake between the queue and the back end.
   typedef struct packed {
      logic valid;
      logic ready;
   } link_type;

   function automatic logic [2:0] group_code(input logic [4:0] idx);
      logic [2:0] code;
      case (idx)
         5'd1, 5'd5, 5'd15, 5'd21:                          code = 3'd1;
         5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: code = 3'd2;
         5'd3, 5'd19:                                       code = 3'd3;
         5'd11:                                             code = 3'd4;
         5'd12, 5'd13:                                      code = 3'd5;
         5'd17:                                             code = 3'd6;
         default:                                           code = CODE_NONE;
      endcase
      return code;
   endfunction

endpackage

@@ design/sdx_front.sv @@
// Front end of the Soundex encoder: takes a byte, folds case and looks up
// its letter group. Depends on sdx_pkg.
module sdx_front (
   input  sdx_pkg::req_type   req_data,
   output sdx_pkg::class_type cls_data
);
   import sdx_pkg::*;

   always_comb begin
      cls_data.letter = 1'b0;
      cls_data.idx    = 5'd0;
      cls_data.last   = req_data.is_final;
      if (req_data.ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         cls_data.letter = 1'b1;
         cls_data.idx    = 5'(req_data.ch - CHAR_LOWER_A);
      end else if (req_data.ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         cls_data.letter = 1'b1;
         cls_data.idx    = 5'(req_data.ch - CHAR_UPPER_A);
      end
      cls_data.code = group_code(cls_data.idx);
   end

endmodule

@@ design/sdx_queue.sv @@
// Short register queue between the front and back ends of the encoder.
// Depends on sdx_pkg for the entry type.
module sdx_queue #(
   parameter int DEPTH = sdx_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sdx_pkg::class_type push_data,
   output sdx_pkg::link_type  pop_link_valid,
   input  logic               pop_ready,
   output sdx_pkg::class_type pop_data
);
   import sdx_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   class_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready           = (count_ff != CNT_W'(DEPTH));
   assign pop_link_valid.valid = (count_ff != '0);
   assign pop_link_valid.ready = pop_ready;
   assign pop_data             = entry_ff[rd_ptr_ff];
   assign push                 = push_valid && push_ready;
   assign pop                  = pop_link_valid.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/sdx_back.sv @@
// Back end of the Soundex encoder: keeps the code being built, one queued
// byte per cycle while no final byte waits, and holds the finished word in
// the output register. Depends on sdx_pkg.
module sdx_back #(
   parameter int CODE_LENGTH = sdx_pkg::CODE_LENGTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  sdx_pkg::link_type  q_link,
   output logic               q_ready,
   input  sdx_pkg::class_type q_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sdx_pkg::rsp_type   rsp_data
);
   import sdx_pkg::*;

   localparam int LIMIT_INT = (CODE_LENGTH - 1 > DIGIT_SLOTS) ? DIGIT_SLOTS :
                              (CODE_LENGTH - 1 < 0) ? 0 : CODE_LENGTH - 1;
   localparam logic [1:0] DIGIT_LIMIT = 2'(LIMIT_INT);

   logic [4:0] first_ff, first_in;
   logic       have_ff, have_in;
   logic [2:0] prev_ff, prev_in;
   logic [1:0] count_ff, count_in;
   logic [2:0] held_ff [DIGIT_SLOTS];
   logic [2:0] held_in [DIGIT_SLOTS];
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       pop, finish;

   // A final byte needs the output register free; other bytes never wait.
   assign q_ready   = !q_data.last || !rsp_valid_ff || rsp_ready;
   assign pop       = q_link.valid && q_ready;
   assign finish    = pop && q_data.last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      first_in    = first_ff;
      have_in     = have_ff;
      prev_in     = prev_ff;
      count_in    = count_ff;
      held_in     = held_ff;
      rsp_data_in = rsp_data_ff;

      if (pop && q_data.letter) begin
         if (!have_ff) begin
            have_in  = 1'b1;
            first_in = q_data.idx;
            prev_in  = q_data.code;
         end else if (q_data.code != prev_ff) begin
            prev_in = q_data.code;
            if (q_data.code != CODE_NONE && count_ff < DIGIT_LIMIT) begin
               held_in[count_ff] = q_data.code;
               count_in          = count_ff + 1'b1;
            end
         end
      end

      if (finish) begin
         if (have_in) begin
            rsp_data_in.lead_letter = LEAD_BASE + {2'b00, first_in};
            rsp_data_in.code_one    = held_in[0];
            rsp_data_in.code_two    = held_in[1];
            rsp_data_in.code_three  = held_in[2];
            rsp_data_in.no_letters  = 1'b0;
         end else begin
            rsp_data_in            = '0;
            rsp_data_in.no_letters = 1'b1;
         end
         first_in = '0;
         have_in  = 1'b0;
         prev_in  = CODE_NONE;
         count_in = '0;
         for (int i = 0; i < DIGIT_SLOTS; i++) begin
            held_in[i] = CODE_NONE;
         end
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= '0;
         have_ff      <= 1'b0;
         prev_ff      <= CODE_NONE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DIGIT_SLOTS; i++) begin
            held_ff[i] <= CODE_NONE;
         end
      end else begin
         first_ff     <= first_in;
         have_ff      <= have_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // The digit count never passes the number of digits the code may carry.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DIGIT_LIMIT)
      else $error("digit count beyond limit");

   // Finishing a name leaves the state cleared for the next one.
   a_clear_after_final: assert property (@(posedge clock) disable iff (reset)
      finish |=> (!have_ff && count_ff == 2'd0))
      else $error("state not cleared after final byte");

   // Digits can only be stored once a first letter is held.
   a_digits_need_letter: assert property (@(posedge clock) disable iff (reset)
      !have_ff |-> (count_ff == 2'd0))
      else $error("digits held without a first letter");

   // A waiting result is never overwritten by a new final byte.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !finish)
      else $error("result overwritten while stalled");
`endif

endmodule

@@ design/soundex_encoder.sv @@
// Soundex encoder, top level: front end, queue and back end.
// Depends on sdx_pkg, sdx_front, sdx_queue and sdx_back.
//
// Use: a name enters on the req_ channel one byte per word, with is_final
// set on its last byte. Bytes that are not letters are dropped; case is
// folded. On the final byte one word leaves on the rsp_ channel: the first
// letter and three code digits (zero padded), or no_letters when the name
// held no letter. Other bytes give no result.
// Throughput: one byte per cycle while req_ready is high. A byte is
// classified as it enters the two-entry queue; the back end updates the
// code from one queued byte per cycle unless a final byte waits, and
// the result word is registered as the final byte leaves the queue.
// Stall: the result waits in the output register while rsp_ready is low.
// Non-final bytes keep flowing; a final byte waits in the queue until the
// output register is free, and req_ready falls once the queue is full.
// Reset: synchronous; clears the queue, the code being built and the
// output valid. The block takes bytes as soon as reset is low.
module soundex_encoder #(
   parameter int CODE_LENGTH = sdx_pkg::CODE_LENGTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sdx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sdx_pkg::rsp_type rsp_data
);
   import sdx_pkg::*;

   class_type cls_data;
   class_type q_data;
   link_type  q_link;
   logic      q_ready;

   sdx_front u_front (
      .req_data (req_data),
      .cls_data (cls_data)
   );

   sdx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock          (clock),
      .reset          (reset),
      .push_valid     (req_valid),
      .push_ready     (req_ready),
      .push_data      (cls_data),
      .pop_link_valid (q_link),
      .pop_ready      (q_ready),
      .pop_data       (q_data)
   );

   sdx_back #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_link    (q_link),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/soundex_checker.sv @@
// Checker for the Soundex encoder: watches both channels, keeps its own copy of
// the code being built and compares every result word with the expected one.
// Depends on sdx_pkg for the word types and character constants.
module soundex_checker #(
   parameter int CODE_LENGTH = sdx_pkg::CODE_LENGTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  sdx_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  sdx_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import sdx_pkg::*;

   localparam int DIGIT_LIMIT = (CODE_LENGTH - 1 < DIGIT_SLOTS) ? CODE_LENGTH - 1 : DIGIT_SLOTS;
   // Group digit of each letter, A first.
   localparam string GROUP_DIGITS = "01230120022455012623010202";

   logic [4:0] lead_idx    = '0;
   logic       seen_letter = 1'b0;
   logic [2:0] last_code   = CODE_NONE;
   int         n_digits    = 0;
   logic [2:0] digits [DIGIT_SLOTS] = '{default: CODE_NONE};
   int         mismatches  = 0;
   rsp_type    expected_codes [$];
   rsp_type    want;

   task automatic clear_name();
      lead_idx = '0;
      seen_letter = 1'b0;
      last_code = CODE_NONE;
      n_digits = 0;
      foreach (digits[i]) digits[i] = CODE_NONE;
   endtask

   // Folds one accepted byte into the code; a final byte yields the expected word.
   task automatic absorb_byte(input req_type w);
      int         letter_no;
      logic [2:0] grp;
      rsp_type    res;
      letter_no = -1;
      if (w.ch >= CHAR_LOWER_A && w.ch <= CHAR_LOWER_Z) letter_no = int'(w.ch - CHAR_LOWER_A);
      else if (w.ch >= CHAR_UPPER_A && w.ch <= CHAR_UPPER_Z) letter_no = int'(w.ch - CHAR_UPPER_A);
      if (letter_no >= 0) begin
         grp = 3'(GROUP_DIGITS[letter_no] - "0");
         if (!seen_letter) begin
            // The first letter's group still counts as the previous code.
            seen_letter = 1'b1;
            lead_idx = 5'(letter_no);
            last_code = grp;
         end else if (grp != last_code) begin
            last_code = grp;
            if (grp != CODE_NONE && n_digits < DIGIT_LIMIT) begin
               digits[n_digits] = grp;
               n_digits++;
            end
         end
      end
      if (w.is_final) begin
         res = '0;
         if (seen_letter) begin
            res.lead_letter = LEAD_BASE + {2'b00, lead_idx};
            res.code_one = digits[0];
            res.code_two = digits[1];
            res.code_three = digits[2];
         end else begin
            res.no_letters = 1'b1;
         end
         expected_codes = {expected_codes, res};
         clear_name();
      end
   endtask

   task automatic note_mismatch(input string what, input int exp_val, input int act_val);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               mismatches++;
               $display("%0t: result word with none expected, expected nothing, actual %h",
                        $time, rsp_data);
            end else begin
               want = expected_codes.pop_front();
               if (rsp_data.lead_letter !== want.lead_letter)
                  note_mismatch("lead_letter", want.lead_letter, rsp_data.lead_letter);
               if (rsp_data.code_one !== want.code_one)
                  note_mismatch("code_one", want.code_one, rsp_data.code_one);
               if (rsp_data.code_two !== want.code_two)
                  note_mismatch("code_two", want.code_two, rsp_data.code_two);
               if (rsp_data.code_three !== want.code_three)
                  note_mismatch("code_three", want.code_three, rsp_data.code_three);
               if (rsp_data.no_letters !== want.no_letters)
                  note_mismatch("no_letters", want.no_letters, rsp_data.no_letters);
            end
         end
         if (req_valid && req_ready) absorb_byte(req_data);
      end
      // Published after the edge so that the stimulus reads settled values.
      pending <= expected_codes.size();
      error_count <= mismatches;
   end

endmodule

@@ tb/testbench.sv @@
// Top of the Soundex encoder testbench: clock, reset, name stimulus, result
// back-pressure, watchdog and verdict. Depends on sdx_pkg, soundex_encoder
// and soundex_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sdx_pkg::*;

   localparam int CODE_LEN       = CODE_LENGTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 48;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 245;
   localparam int SETTLE_CYCLES  = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int error_count;
   int pending;
   int stall_cycles = 0;
   int gap_pct      = 0;
   int idle_pct     = 0;
   bit hold_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   soundex_encoder #(.CODE_LENGTH(CODE_LEN)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   soundex_checker #(.CODE_LENGTH(CODE_LEN)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .error_count(error_count), .pending(pending)
   );

   // Result side: random stall bursts, and one long hold when asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offers one word and returns at the edge where it is taken. Valid stays
   // high into the next word unless a gap is drawn.
   task automatic send_byte(input logic [7:0] byte_val, input logic fin);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{ch: byte_val, is_final: fin};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // Sender pause: nothing offered until every expected result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // A random name of up to max_len letters in mixed case, with stray bytes
   // scattered in and now and then a stray final byte. Returns the letter
   // count plus one, so stray bytes are not counted.
   task automatic send_name(input int max_len, input int noise_pct, output int counted);
      logic [7:0] name_bytes [$];
      int         len;
      int         letter_no;
      int         prev_no;
      len = $urandom_range(0, max_len);
      prev_no = -1;
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 99) < noise_pct)
            name_bytes = {name_bytes, 8'($urandom_range(0, 255))};
         letter_no = $urandom_range(0, 25);
         if (prev_no >= 0 && $urandom_range(0, 3) == 0) letter_no = prev_no;
         prev_no = letter_no;
         name_bytes = {name_bytes,
                       8'(($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(letter_no))};
      end
      if (len == 0 || $urandom_range(0, 9) == 0)
         name_bytes = {name_bytes, 8'($urandom_range(0, 255))};
      foreach (name_bytes[i]) send_byte(name_bytes[i], i == name_bytes.size() - 1);
      counted = len + 1;
   endtask

   initial begin
      int max_len;
      int noise_pct;
      int sent;
      int counted;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed names: empty names on the lowest and highest byte, a lone
      // lower case letter, folded repeats of the last letter, a stray final
      // byte, truncation, a vowel breaking a run and a stray byte that does not.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_text("a");
      send_text("Zz");
      send_text("Mcgklt#");
      send_text("Bdlmr");
      send_text("Tat");
      send_text("T@t");
      drain_results();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         max_len = 8;
         noise_pct = 10;
         case (phase)
            0: begin gap_pct = 0;  idle_pct = 0;  end
            1: begin gap_pct = 30; idle_pct = 30; end
            2: begin
               // Short names so that several finals pile up behind the hold.
               gap_pct = 0; idle_pct = 0; max_len = 3;
               hold_request = 1'b1;
            end
            3: begin gap_pct = 50; idle_pct = 10; noise_pct = 30; end
            4: begin gap_pct = 10; idle_pct = 50; end
            5: begin gap_pct = 0;  idle_pct = 0;  max_len = 12; end
            6: begin gap_pct = 25; idle_pct = 25; end
            default: begin gap_pct = 0; idle_pct = 0; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            send_name(max_len, noise_pct, counted);
            sent += counted;
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/sdx_pkg.sv
design/sdx_front.sv
design/sdx_queue.sv
design/sdx_back.sv
design/soundex_encoder.sv
tb/soundex_checker.sv
tb/testbench.sv
